// File: sv/jca_pkg.sv
// shared types, constants and register codes of the joystick cursor accelerator
// used by every module of the block; depends on nothing

package jca_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 15;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned AxisW  = 16;
    localparam int unsigned ScaleW = 6;
    localparam int unsigned ProdW  = 37;
    localparam int unsigned DivW   = 12;
    localparam int unsigned QuoW   = 16;
    localparam int unsigned LevelW = 4;

    // x / 1000 == (x * 67109) >> 26 for 0 <= x <= 32768
    localparam logic [16:0] RECIP_1000  = 17'd67109;
    localparam int unsigned RECIP_SHIFT = 26;
    localparam int unsigned RECIP_PW    = 33;

    localparam logic [DivW-1:0] RST_BASE_DIV   = 12'd350;
    localparam logic [7:0]      RST_ACCEL_STEP = 8'd30;
    localparam logic [14:0]     RST_DEAD_ZONE  = 15'd1000;
    localparam logic [LevelW-1:0] RST_ACCEL_MAX = 4'd10;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ENABLED    = 3'd0,
        CFG_DEAD_ZONE  = 3'd1,
        CFG_BASE_DIV   = 3'd2,
        CFG_ACCEL_STEP = 3'd3,
        CFG_ACCEL_MAX  = 3'd4
    } jca_cfg_idx_t;

    typedef struct packed {
        logic [TimeW-1:0]        now_ms;
        logic signed [AxisW-1:0] axis_x;
        logic signed [AxisW-1:0] axis_y;
    } jca_in_t;

    typedef struct packed {
        logic signed [AxisW-1:0] delta_x;
        logic signed [AxisW-1:0] delta_y;
        logic                    moved;
        logic [LevelW-1:0]       accel_level;
    } jca_out_t;

    typedef struct packed {
        logic load_in;
        logic scale;
        logic prod;
        logic axis_sel;
        logic div_start;
        logic store;
        logic commit;
    } jca_cmd_t;

    typedef struct packed {
        logic div_done;
    } jca_sts_t;

endpackage

// File: sv/jca_div.sv
// serial restoring divider, one quotient bit per cycle, saturation flag
// for quotients of 2^16 and above; depends on jca_pkg

module jca_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [jca_pkg::ProdW-1:0]  dividend,
    input  logic [jca_pkg::DivW-1:0]   divisor,
    output logic                       done,
    output logic                       sat,
    output logic [jca_pkg::QuoW-1:0]   quotient
);
    import jca_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              sat_reg, sat_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [DivW-1:0]   rem_reg, rem_next;
    logic [QuoW-1:0]   quo_reg, quo_next;
    logic [DivW:0]     trial;
    logic [DivW:0]     trial_sub;

    assign trial     = {rem_reg, quo_reg[QuoW-1]};
    assign trial_sub = trial - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            if (dividend[ProdW-1:QuoW] >= {{(ProdW-QuoW-DivW){1'b0}}, divisor}) begin
                sat_next  = 1'b1;
                done_next = 1'b1;
            end else begin
                sat_next  = 1'b0;
                busy_next = 1'b1;
                cnt_next  = 4'd15;
                rem_next  = dividend[QuoW+DivW-1:QuoW];
                quo_next  = dividend[QuoW-1:0];
            end
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial_sub[DivW-1:0];
                quo_next = {quo_reg[QuoW-2:0], 1'b1};
            end else begin
                rem_next = trial[DivW-1:0];
                quo_next = {quo_reg[QuoW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 4'd1;
            if (cnt_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign sat      = sat_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/jca_dp.sv
// datapath: configuration registers, timestamp and level state, sample scaling,
// product and shared divider, result register; depends on jca_pkg, jca_div

module jca_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [jca_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [jca_pkg::CfgDataW-1:0] cfg_wdata,
    input  jca_pkg::jca_in_t             in_data,
    input  jca_pkg::jca_cmd_t            cmd,
    output jca_pkg::jca_sts_t            sts,
    output jca_pkg::jca_out_t            out_data
);
    import jca_pkg::*;

    logic              enabled_reg;
    logic [14:0]       dead_zone_reg;
    logic [DivW-1:0]   base_div_reg;
    logic [7:0]        accel_step_reg;
    logic [LevelW-1:0] accel_max_reg;

    logic [TimeW-1:0]  last_time_reg;
    logic [LevelW-1:0] accel_reg, accel_next;

    logic [TimeW-1:0]  now_reg;
    logic [TimeW-1:0]  diff_reg;
    logic              active_reg;
    logic [AxisW-1:0]  magx_reg, magy_reg;
    logic              sx_neg_reg, sy_neg_reg;
    logic [DivW-1:0]   div_reg;

    logic [TimeW-1:0]  emag_reg;
    logic              eneg_reg;
    logic [ScaleW-1:0] qx_reg, qy_reg;
    logic              okx_reg, oky_reg;

    logic [ProdW-1:0]  prod_reg;
    logic              neg_reg;

    logic signed [AxisW-1:0] dx_reg, dy_reg;
    jca_out_t          out_reg;

    logic [DivW-1:0]   step_prod;
    logic signed [DivW+1:0] div_s;
    logic [DivW-1:0]   div_clamp;
    logic [RECIP_PW-1:0] scale_x, scale_y;
    logic [ScaleW-1:0] q_sel;
    logic              ok_sel;
    logic [ProdW:0]    prod_full;
    logic              div_done, div_sat;
    logic [QuoW-1:0]   div_quo;
    logic signed [AxisW-1:0] delta;
    logic              moved;
    logic [LevelW:0]   level_inc;

    function automatic logic [AxisW-1:0] mag16(input logic [AxisW-1:0] v);
        return v[AxisW-1] ? (~v + 16'd1) : v;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= 1'b1;
            dead_zone_reg  <= RST_DEAD_ZONE;
            base_div_reg   <= RST_BASE_DIV;
            accel_step_reg <= RST_ACCEL_STEP;
            accel_max_reg  <= RST_ACCEL_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ENABLED:    enabled_reg    <= cfg_wdata[0];
                CFG_DEAD_ZONE:  dead_zone_reg  <= cfg_wdata[14:0];
                CFG_BASE_DIV:   base_div_reg   <= cfg_wdata[DivW-1:0];
                CFG_ACCEL_STEP: accel_step_reg <= cfg_wdata[7:0];
                CFG_ACCEL_MAX:  accel_max_reg  <= cfg_wdata[LevelW-1:0];
                default: ;
            endcase
        end
    end

    // divisor for the current level, clamped to at least one
    assign step_prod = DivW'(accel_step_reg) * DivW'(accel_reg);
    assign div_s     = $signed({2'b00, base_div_reg}) - $signed({2'b00, step_prod});
    assign div_clamp = (div_s < 14'sd1) ? 12'd1 : div_s[DivW-1:0];

    assign scale_x = RECIP_PW'(magx_reg) * RECIP_PW'(RECIP_1000);
    assign scale_y = RECIP_PW'(magy_reg) * RECIP_PW'(RECIP_1000);

    assign q_sel     = cmd.axis_sel ? qy_reg : qx_reg;
    assign ok_sel    = cmd.axis_sel ? oky_reg : okx_reg;
    assign prod_full = (ProdW+1)'(q_sel) * (ProdW+1)'(emag_reg);

    jca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (div_reg),
        .done     (div_done),
        .sat      (div_sat),
        .quotient (div_quo)
    );

    // sign and 16-bit saturation of the quotient
    always_comb begin
        if (neg_reg) begin
            if (div_sat || div_quo > 16'd32768) begin
                delta = 16'sh8000;
            end else begin
                delta = $signed(~div_quo + 16'd1);
            end
        end else begin
            if (div_sat || div_quo > 16'd32767) begin
                delta = 16'sh7fff;
            end else begin
                delta = $signed(div_quo);
            end
        end
    end

    assign moved     = (dx_reg != '0) || (dy_reg != '0);
    assign level_inc = {1'b0, accel_reg} + 5'd1;

    always_comb begin
        if (!moved) begin
            accel_next = '0;
        end else if (level_inc > {1'b0, accel_max_reg}) begin
            accel_next = accel_max_reg;
        end else begin
            accel_next = level_inc[LevelW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            accel_reg     <= '0;
        end else if (cmd.commit) begin
            last_time_reg <= now_reg;
            accel_reg     <= accel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            now_reg    <= in_data.now_ms;
            diff_reg   <= in_data.now_ms - last_time_reg;
            active_reg <= enabled_reg && (last_time_reg != '0);
            magx_reg   <= mag16(in_data.axis_x);
            magy_reg   <= mag16(in_data.axis_y);
            sx_neg_reg <= in_data.axis_x[AxisW-1];
            sy_neg_reg <= in_data.axis_y[AxisW-1];
            div_reg    <= div_clamp;
        end
        if (cmd.scale) begin
            emag_reg <= diff_reg[TimeW-1] ? (~diff_reg + 32'd1) : diff_reg;
            eneg_reg <= diff_reg[TimeW-1];
            qx_reg   <= scale_x[RECIP_SHIFT+ScaleW-1:RECIP_SHIFT];
            qy_reg   <= scale_y[RECIP_SHIFT+ScaleW-1:RECIP_SHIFT];
            okx_reg  <= magx_reg > {1'b0, dead_zone_reg};
            oky_reg  <= magy_reg > {1'b0, dead_zone_reg};
        end
        if (cmd.prod) begin
            prod_reg <= (active_reg && ok_sel) ? prod_full[ProdW-1:0] : '0;
            neg_reg  <= (cmd.axis_sel ? sy_neg_reg : sx_neg_reg) ^ eneg_reg;
        end
        if (cmd.store) begin
            if (cmd.axis_sel) begin
                dy_reg <= delta;
            end else begin
                dx_reg <= delta;
            end
        end
        if (cmd.commit) begin
            out_reg.delta_x     <= dx_reg;
            out_reg.delta_y     <= dy_reg;
            out_reg.moved       <= moved;
            out_reg.accel_level <= accel_next;
        end
    end

    assign sts.div_done = div_done;
    assign out_data     = out_reg;

endmodule

// File: sv/jca_ctrl.sv
// controller: sequences scaling, product and the two divisions of one request,
// and holds the result valid flag; depends on jca_pkg

module jca_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  jca_pkg::jca_sts_t  sts,
    output jca_pkg::jca_cmd_t  cmd
);
    import jca_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_PROD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   axis_reg, axis_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.axis_sel = axis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    axis_next   = 1'b0;
                    state_next  = ST_SCALE;
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (sts.div_done) begin
                    cmd.store = 1'b1;
                    if (axis_reg) begin
                        state_next = ST_COMMIT;
                    end else begin
                        axis_next  = 1'b1;
                        state_next = ST_PROD;
                    end
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            axis_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: sv/joystick_cursor_accelerator.sv
// Joystick cursor accelerator: turns timestamped two-axis joystick samples into
// cursor movement with a rising acceleration level.
// Depends on jca_pkg, jca_ctrl, jca_dp (which holds jca_div).
//
// Input channel s_valid/s_ready/s_data carries one request: a millisecond
// timestamp and a signed sample per axis. Output channel m_valid/m_ready/m_data
// returns exactly one result per request: saturated x and y deltas, a moved flag
// and the acceleration level after the update.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_wdata,
// one register per cycle. The user must write them only while no request is
// in flight; the block itself does not enforce this. One request is processed
// at a time: a new one is accepted only after the last has been committed to
// the output register. The serial divider works on each axis in turn, and a
// saturating quotient skips the serial division.
// Reset (aresetn low, synchronous) clears the stored timestamp and level, loads
// the register defaults and empties the output register.
// While m_ready is low the finished result is held; the next request is still
// accepted and processed, and it waits before its result stage until the
// previous result has been taken.

module joystick_cursor_accelerator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  jca_pkg::jca_in_t             s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output jca_pkg::jca_out_t            m_data,
    input  logic                         cfg_wr_en,
    input  logic [jca_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [jca_pkg::CfgDataW-1:0] cfg_wdata
);
    import jca_pkg::*;

    jca_cmd_t cmd;
    jca_sts_t sts;

    jca_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    jca_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_data  (m_data)
    );

`ifndef SYNTHESIS
    // one request at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
    else $error("request accepted while another is in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.moved) |-> (m_data.accel_level == '0))
    else $error("level not cleared on a still update");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.moved) |-> (m_data.delta_x == '0 && m_data.delta_y == '0))
    else $error("moved flag disagrees with deltas");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
    else $error("result changed while stalled");
`endif

endmodule
